// ----- src/waveform_minmax_decimator_macros.svh -----
// Assertion macros for the waveform min/max decimator.
`ifndef WAVEFORM_MINMAX_DECIMATOR_MACROS_SVH
`define WAVEFORM_MINMAX_DECIMATOR_MACROS_SVH

`ifndef SYNTHESIS

`define WMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmd assertion failed");

`define WMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmd assertion failed");

`else

`define WMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define WMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/wmd_pkg.sv -----
`default_nettype none

package wmd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FRAME_W     = 32;
    localparam int COL_W       = 7;
    localparam int IDX_W       = 6;
    localparam int PEAK_W      = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_COLUMNS = 64;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_DIV,
        ST_START,
        ST_IDLE,
        ST_CHECK,
        ST_BOUND
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
        logic close;
        logic bound;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic col_due;
        logic out_free;
        logic last_col;
    } t_dp_sts;

    function automatic logic [PEAK_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
        logic [PEAK_W-1:0] ext;
        ext = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
    endfunction

endpackage

`default_nettype wire

// ----- src/wmd_div.sv -----
`default_nettype none

module wmd_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [wmd_pkg::FRAME_W-1:0]  i_dividend,
    input  wire logic [wmd_pkg::COL_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [wmd_pkg::FRAME_W-1:0]       o_quot,
    output logic [wmd_pkg::COL_W-1:0]         o_rem
);

    localparam int CntW = $clog2(wmd_pkg::FRAME_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CntW-1:0]               r_count;
    logic [wmd_pkg::FRAME_W-1:0]   r_quot;
    logic [wmd_pkg::COL_W-1:0]     r_rem;
    logic [wmd_pkg::COL_W-1:0]     r_divisor;

    logic [wmd_pkg::COL_W:0]       trial;
    logic                          fits;
    logic [wmd_pkg::COL_W:0]       diff;

    // One quotient bit per cycle, restoring.
    always_comb begin
        trial = {r_rem, r_quot[wmd_pkg::FRAME_W-1]};
        fits  = (trial >= {1'b0, r_divisor});
        diff  = trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= CntW'(wmd_pkg::FRAME_W - 1);
        end else if (r_busy) begin
            r_count <= r_count - 1'b1;
            if (r_count == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[wmd_pkg::FRAME_W-2:0], fits};
            r_rem  <= fits ? diff[wmd_pkg::COL_W-1:0] : trial[wmd_pkg::COL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- src/wmd_ctrl.sv -----
`default_nettype none

module wmd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_cfg_we,
    input  wire wmd_pkg::t_dp_sts i_sts,
    output wmd_pkg::t_dp_cmd      o_cmd,
    output logic                  o_in_stall
);

    wmd_pkg::t_state r_state;
    wmd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmd_pkg::ST_DIV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = wmd_pkg::ST_DIV;
        end else begin
            unique case (r_state)
                wmd_pkg::ST_DIV: begin
                    if (i_sts.div_done) n_state = wmd_pkg::ST_START;
                end
                wmd_pkg::ST_START: n_state = wmd_pkg::ST_IDLE;
                wmd_pkg::ST_IDLE: begin
                    if (i_valid) n_state = wmd_pkg::ST_CHECK;
                end
                wmd_pkg::ST_CHECK: begin
                    priority if (!i_sts.col_due) n_state = wmd_pkg::ST_IDLE;
                    else if (i_sts.out_free && i_sts.last_col) n_state = wmd_pkg::ST_START;
                    else if (i_sts.out_free) n_state = wmd_pkg::ST_BOUND;
                    else n_state = wmd_pkg::ST_CHECK;
                end
                wmd_pkg::ST_BOUND: n_state = wmd_pkg::ST_CHECK;
                default: n_state = wmd_pkg::ST_DIV;
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            wmd_pkg::ST_DIV: ;
            wmd_pkg::ST_START: o_cmd.bound = 1'b1;
            wmd_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_valid;
            end
            wmd_pkg::ST_CHECK: begin
                o_cmd.close = !i_sts.col_due;
                o_cmd.emit  = i_sts.col_due && i_sts.out_free;
            end
            wmd_pkg::ST_BOUND: o_cmd.bound = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/wmd_datapath.sv -----
`default_nettype none

module wmd_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [wmd_pkg::FRAME_W-1:0]         i_cfg_data,
    input  wire logic signed [wmd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_stall,
    input  wire wmd_pkg::t_dp_cmd                    i_cmd,
    output wmd_pkg::t_dp_sts                         o_sts,
    output logic                                     o_valid,
    output logic [wmd_pkg::IDX_W-1:0]                o_column_index,
    output logic signed [wmd_pkg::SAMPLE_W-1:0]      o_column_min,
    output logic signed [wmd_pkg::SAMPLE_W-1:0]      o_column_max,
    output logic [wmd_pkg::SAMPLE_W-1:0]             o_peak,
    output logic                                     o_last
);

    localparam int FW = wmd_pkg::FRAME_W;
    localparam int CW = wmd_pkg::COL_W;
    localparam int SW = wmd_pkg::SAMPLE_W;
    localparam int PW = wmd_pkg::PEAK_W;

    // configuration
    logic [FW-1:0]        r_frame_count;
    logic [CW-1:0]        r_column_count;
    logic [FW-1:0]        n_frame_count;
    logic [CW-1:0]        n_column_count;
    logic [FW-1:0]        n_frames_eff;
    logic [CW-1:0]        n_cols_eff;
    logic [CW-1:0]        cols_eff;
    logic                 r_boot;
    logic                 div_start;

    // divider results: frames = step_q * cols + step_r
    logic                 div_done;
    logic [FW-1:0]        div_quot;
    logic [CW-1:0]        div_rem;
    logic [FW-1:0]        r_step_q;
    logic [CW-1:0]        r_step_r;

    // window state
    logic [FW-1:0]        r_pos;
    logic [CW-1:0]        r_col;
    logic [FW-1:0]        r_lo_q;
    logic [CW-1:0]        r_lo_r;
    logic [FW-1:0]        r_col_end;
    logic signed [SW-1:0] r_min;
    logic signed [SW-1:0] r_max;
    logic signed [SW-1:0] r_sample;
    logic [PW-1:0]        r_peak;
    logic                 r_emitted;

    // output register
    logic                 r_out_valid;
    logic [wmd_pkg::IDX_W-1:0] r_out_index;
    logic signed [SW-1:0] r_out_min;
    logic signed [SW-1:0] r_out_max;
    logic [SW-1:0]        r_out_peak;
    logic                 r_out_last;

    logic [CW:0]          sum_r;
    logic [CW:0]          wrap_r;
    logic                 carry;
    logic [CW-1:0]        next_r;
    logic [FW-1:0]        next_q;
    logic [PW-1:0]        mag_min;
    logic [PW-1:0]        mag_max;
    logic [PW-1:0]        peak_a;
    logic [PW-1:0]        peak_new;
    logic                 last_col;
    logic                 out_free;

    always_comb begin
        n_frame_count  = r_frame_count;
        n_column_count = r_column_count;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wmd_pkg::CFG_FRAME_COUNT:  n_frame_count  = i_cfg_data;
                wmd_pkg::CFG_COLUMN_COUNT: n_column_count = i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [CW-1:0] eff_cols(input logic [CW-1:0] c);
        if (c == '0) return CW'(1);
        if (c > CW'(wmd_pkg::MAX_COLUMNS)) return CW'(wmd_pkg::MAX_COLUMNS);
        return c;
    endfunction

    assign n_frames_eff = (n_frame_count == '0) ? FW'(1) : n_frame_count;
    assign n_cols_eff   = eff_cols(n_column_count);
    assign cols_eff     = eff_cols(r_column_count);
    assign div_start    = i_cfg_we || r_boot;

    wmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_frames_eff),
        .i_divisor  (n_cols_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Step the column start floor(F*k/C) by one column.
    always_comb begin
        sum_r  = {1'b0, r_lo_r} + {1'b0, r_step_r};
        carry  = (sum_r >= {1'b0, cols_eff});
        wrap_r = sum_r - {1'b0, cols_eff};
        next_r = carry ? wrap_r[CW-1:0] : sum_r[CW-1:0];
        next_q = r_lo_q + r_step_q + {{(FW-1){1'b0}}, carry};
    end

    always_comb begin
        mag_min  = wmd_pkg::mag(r_min);
        mag_max  = wmd_pkg::mag(r_max);
        peak_a   = (mag_max > r_peak) ? mag_max : r_peak;
        peak_new = (mag_min > peak_a) ? mag_min : peak_a;
        last_col = ((r_col + 1'b1) == cols_eff);
        out_free = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= FW'(1);
            r_column_count <= CW'(wmd_pkg::MAX_COLUMNS);
            r_boot         <= 1'b1;
            r_step_q       <= '0;
            r_step_r       <= '0;
        end else begin
            r_frame_count  <= n_frame_count;
            r_column_count <= n_column_count;
            r_boot         <= 1'b0;
            if (div_done) begin
                r_step_q <= div_quot;
                r_step_r <= div_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_pos     <= '0;
            r_col     <= '0;
            r_lo_q    <= '0;
            r_lo_r    <= '0;
            r_col_end <= FW'(1);
            r_min     <= wmd_pkg::SAMPLE_MAX;
            r_max     <= wmd_pkg::SAMPLE_MIN;
            r_peak    <= PW'(1);
            r_emitted <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_sample  <= i_sample;
                r_pos     <= r_pos + 1'b1;
                r_emitted <= 1'b0;
                if (i_sample < r_min) r_min <= i_sample;
                if (i_sample > r_max) r_max <= i_sample;
            end
            if (i_cmd.bound) begin
                r_col_end <= (next_q == r_lo_q) ? (r_lo_q + 1'b1) : next_q;
            end
            if (i_cmd.close && r_emitted) begin
                r_min <= wmd_pkg::SAMPLE_MAX;
                r_max <= wmd_pkg::SAMPLE_MIN;
            end
            if (i_cmd.emit) begin
                if (last_col) begin
                    // window done: rewind
                    r_pos     <= '0;
                    r_col     <= '0;
                    r_lo_q    <= '0;
                    r_lo_r    <= '0;
                    r_min     <= wmd_pkg::SAMPLE_MAX;
                    r_max     <= wmd_pkg::SAMPLE_MIN;
                    r_peak    <= PW'(1);
                    r_emitted <= 1'b0;
                end else begin
                    r_col     <= r_col + 1'b1;
                    r_lo_q    <= next_q;
                    r_lo_r    <= next_r;
                    r_min     <= r_sample;
                    r_max     <= r_sample;
                    r_peak    <= peak_new;
                    r_emitted <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_index <= r_col[wmd_pkg::IDX_W-1:0];
            r_out_min   <= r_min;
            r_out_max   <= r_max;
            r_out_peak  <= peak_new[SW-1:0];
            r_out_last  <= last_col;
        end
    end

    always_comb begin
        o_sts.div_done = div_done;
        o_sts.col_due  = (r_col_end <= r_pos);
        o_sts.out_free = out_free;
        o_sts.last_col = last_col;
    end

    assign o_valid        = r_out_valid;
    assign o_column_index = r_out_index;
    assign o_column_min   = r_out_min;
    assign o_column_max   = r_out_max;
    assign o_peak         = r_out_peak;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ----- src/waveform_minmax_decimator.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------------
// sample    | in        | i_valid / o_stall  | i_sample
// column    | out       | o_valid / i_stall  | o_column_index, o_column_min, o_column_max,
//           |           |                    | o_peak, o_last
// config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A sample word is accepted in IDLE and checked in CHECK; each column it closes
// adds a step to send the column word and a step to set the next column boundary.
// Reset and every config write start a frames/columns division in the boundary
// divider; the sample input stalls until the division is done and a boundary is set.
// A stalled column word holds the column sequencer until the word is taken.
`default_nettype none

`include "waveform_minmax_decimator_macros.svh"

module waveform_minmax_decimator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [wmd_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [wmd_pkg::IDX_W-1:0]                o_column_index,
    output logic signed [wmd_pkg::SAMPLE_W-1:0]      o_column_min,
    output logic signed [wmd_pkg::SAMPLE_W-1:0]      o_column_max,
    output logic [wmd_pkg::SAMPLE_W-1:0]             o_peak,
    output logic                                     o_last,
    input  wire logic                                i_cfg_we,
    input  wire logic [wmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [wmd_pkg::FRAME_W-1:0]         i_cfg_data
);

    wmd_pkg::t_dp_cmd dp_cmd;
    wmd_pkg::t_dp_sts dp_sts;

    wmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_stall)
    );

    wmd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_stall        (i_stall),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_valid        (o_valid),
        .o_column_index (o_column_index),
        .o_column_min   (o_column_min),
        .o_column_max   (o_column_max),
        .o_peak         (o_peak),
        .o_last         (o_last)
    );

    `WMD_ASSERT_IMP(a_emit_has_room, i_clk, i_rst_n, dp_cmd.emit, dp_sts.out_free)
    `WMD_ASSERT_IMP(a_no_accept_emit, i_clk, i_rst_n, dp_cmd.accept, !dp_cmd.emit && !dp_cmd.bound)
    `WMD_ASSERT_NXT(a_cfg_stalls_input, i_clk, i_rst_n, i_cfg_we, o_stall)
    `WMD_ASSERT_IMP(a_peak_nonzero, i_clk, i_rst_n, o_valid, o_peak != '0)

endmodule

`default_nettype wire
